// File: hw/rtl/periodic_gaussian_smooth_3d_defines.svh
// Assertion macros for the smoothing block.
// Each macro carries its own clock and active-low reset.
`ifndef PERIODIC_GAUSSIAN_SMOOTH_3D_DEFINES_SVH
`define PERIODIC_GAUSSIAN_SMOOTH_3D_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PGS3D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression must never be true outside reset.
`define PGS3D_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PGS3D_ASSERT(lbl, clk, rstn, prop, msg)
`define PGS3D_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: hw/rtl/pgs3d_pkg.sv
`timescale 1ns / 1ps
package pgs3d_pkg;

  // Fixed field widths
  localparam int COORD_W    = 5;
  localparam int SIZE_W     = 6;
  localparam int SMP_W      = 16;
  localparam int WGT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SIDE   = 3'd4;

  // Input item
  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [SMP_W-1:0]   sample;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [SMP_W-1:0] smoothed;
    logic             range_error;
  } out_item_t;

  // Per-tap control from the sequencer to the MAC pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic side_x;
    logic side_y;
    logic side_z;
  } tap_ctl_t;

endpackage

// File: hw/rtl/pgs3d_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, one read port, registered read data.
module pgs3d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pgs3d_seq.sv
`timescale 1ns / 1ps
// Neighborhood sequencer: walks the 27 wrapped neighbors, one read address a cycle.
module pgs3d_seq #(
  parameter int MAX_DIM = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                launch,
  input  logic [pgs3d_pkg::COORD_W-1:0]       coord_x,
  input  logic [pgs3d_pkg::COORD_W-1:0]       coord_y,
  input  logic [pgs3d_pkg::COORD_W-1:0]       coord_z,
  input  logic [pgs3d_pkg::SIZE_W-1:0]        size_x,
  input  logic [pgs3d_pkg::SIZE_W-1:0]        size_y,
  input  logic [pgs3d_pkg::SIZE_W-1:0]        size_z,
  output logic [((MAX_DIM * MAX_DIM * MAX_DIM > 1) ?
                 $clog2(MAX_DIM * MAX_DIM * MAX_DIM) : 1)-1:0] raddr,
  output pgs3d_pkg::tap_ctl_t                 tap_ctl,
  output logic                                active
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIZE_W = pgs3d_pkg::SIZE_W;

  // Offset codes: minus one, zero, plus one
  localparam logic [1:0] TAP_MINUS  = 2'd0;
  localparam logic [1:0] TAP_CENTER = 2'd1;
  localparam logic [1:0] TAP_PLUS   = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  logic [1:0]        tx_r, ty_r, tz_r;
  logic [1:0]        tx_nxt, ty_nxt, tz_nxt;
  logic [SIZE_W-1:0] nbr_x_r [3];
  logic [SIZE_W-1:0] nbr_y_r [3];
  logic [SIZE_W-1:0] nbr_z_r [3];
  logic [SIZE_W-1:0] cx, cy, cz;
  logic [SIZE_W-1:0] sel_x, sel_y, sel_z;
  logic              last_tap;

  assign cx = SIZE_W'(coord_x);
  assign cy = SIZE_W'(coord_y);
  assign cz = SIZE_W'(coord_z);

  // Wrapped neighbor coordinates, latched at launch
  always_ff @(posedge clk) begin
    if (launch) begin
      nbr_x_r[TAP_MINUS]  <= (cx == '0) ? size_x - SIZE_W'(1) : cx - SIZE_W'(1);
      nbr_x_r[TAP_CENTER] <= cx;
      nbr_x_r[TAP_PLUS]   <= (cx + SIZE_W'(1) >= size_x) ? '0 : cx + SIZE_W'(1);
      nbr_y_r[TAP_MINUS]  <= (cy == '0) ? size_y - SIZE_W'(1) : cy - SIZE_W'(1);
      nbr_y_r[TAP_CENTER] <= cy;
      nbr_y_r[TAP_PLUS]   <= (cy + SIZE_W'(1) >= size_y) ? '0 : cy + SIZE_W'(1);
      nbr_z_r[TAP_MINUS]  <= (cz == '0) ? size_z - SIZE_W'(1) : cz - SIZE_W'(1);
      nbr_z_r[TAP_CENTER] <= cz;
      nbr_z_r[TAP_PLUS]   <= (cz + SIZE_W'(1) >= size_z) ? '0 : cz + SIZE_W'(1);
    end
  end

  assign last_tap = (tx_r == TAP_PLUS) && (ty_r == TAP_PLUS) && (tz_r == TAP_PLUS);

  // Tap counters, x innermost; all three wrap back to minus one after the last tap
  always_comb begin
    state_nxt = state_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    tz_nxt    = tz_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (launch) begin
          state_nxt = SEQ_RUN;
          tx_nxt    = TAP_MINUS;
          ty_nxt    = TAP_MINUS;
          tz_nxt    = TAP_MINUS;
        end
      end
      SEQ_RUN: begin
        if (last_tap) begin
          state_nxt = SEQ_IDLE;
        end
        if (tx_r == TAP_PLUS) begin
          tx_nxt = TAP_MINUS;
          if (ty_r == TAP_PLUS) begin
            ty_nxt = TAP_MINUS;
            tz_nxt = (tz_r == TAP_PLUS) ? TAP_MINUS : tz_r + 2'd1;
          end else begin
            ty_nxt = ty_r + 2'd1;
          end
        end else begin
          tx_nxt = tx_r + 2'd1;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      tx_r    <= TAP_MINUS;
      ty_r    <= TAP_MINUS;
      tz_r    <= TAP_MINUS;
    end else begin
      state_r <= state_nxt;
      tx_r    <= tx_nxt;
      ty_r    <= ty_nxt;
      tz_r    <= tz_nxt;
    end
  end

  // Read address of the current neighbor
  assign sel_x = nbr_x_r[tx_r];
  assign sel_y = nbr_y_r[ty_r];
  assign sel_z = nbr_z_r[tz_r];
  assign raddr = ADDR_W'(sel_x) + ADDR_W'(MAX_DIM) *
                 (ADDR_W'(sel_y) + ADDR_W'(MAX_DIM) * ADDR_W'(sel_z));

  assign active         = (state_r == SEQ_RUN);
  assign tap_ctl.valid  = active;
  assign tap_ctl.last   = last_tap;
  assign tap_ctl.side_x = (tx_r != TAP_CENTER);
  assign tap_ctl.side_y = (ty_r != TAP_CENTER);
  assign tap_ctl.side_z = (tz_r != TAP_CENTER);

endmodule

// File: hw/rtl/pgs3d_mac.sv
`timescale 1ns / 1ps
// Weight and multiply-accumulate pipeline, rounding and saturation at the end.
module pgs3d_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            launch,
  input  pgs3d_pkg::tap_ctl_t             tap_ctl,
  input  logic [SAMPLE_BITS-1:0]          rd_data,
  input  logic [pgs3d_pkg::WGT_W-1:0]     weight_center,
  input  logic [pgs3d_pkg::WGT_W-1:0]     weight_side,
  output logic                            done,
  output logic [pgs3d_pkg::SMP_W-1:0]     smoothed,
  output logic                            pending
);

  localparam int WGT_W  = pgs3d_pkg::WGT_W;
  localparam int SMP_W  = pgs3d_pkg::SMP_W;
  localparam int PROD_W = SAMPLE_BITS + WGT_W;
  // 27 products need 5 more bits; keep at least 32 so the saturate compare is wide
  localparam int ACC_W  = (PROD_W + 5 > 32) ? PROD_W + 5 : 32;
  localparam int RES_W  = ACC_W + 1 - 16;
  localparam logic [SMP_W-1:0] SAT_MAX = '1;

  logic [WGT_W-1:0]   wa, wb;
  logic [2*WGT_W-1:0] wab, wxyz;
  logic [WGT_W-1:0]   wxy_r, wz_r, w_r;
  logic [SAMPLE_BITS-1:0] data_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ACC_W:0]     rnd;
  logic [SMP_W-1:0]   sat_nxt, smoothed_r;
  logic               s1_valid_r, s1_last_r;
  logic               s2_valid_r, s2_last_r;
  logic               s3_valid_r, s3_last_r;
  logic               s4_last_r, done_r;

  // Stage 1: x*y tap product, issued with the read address
  assign wa  = tap_ctl.side_x ? weight_side : weight_center;
  assign wb  = tap_ctl.side_y ? weight_side : weight_center;
  assign wab = wa * wb;

  // Stage 2: times z tap, memory data lands
  assign wxyz = wxy_r * wz_r;

  // Stage 4: accumulate, cleared when a query starts
  always_comb begin
    acc_nxt = acc_r;
    if (launch) begin
      acc_nxt = '0;
    end else if (s3_valid_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  // Stage 5: round half up and saturate
  assign rnd     = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(32768);
  assign sat_nxt = (rnd[ACC_W:16] > RES_W'(SAT_MAX)) ? SAT_MAX : rnd[31:16];

  // Datapath registers
  always_ff @(posedge clk) begin
    wxy_r  <= wab[2*WGT_W-1:WGT_W];
    wz_r   <= tap_ctl.side_z ? weight_side : weight_center;
    w_r    <= wxyz[2*WGT_W-1:WGT_W];
    data_r <= rd_data;
    prod_r <= data_r * w_r;
    acc_r  <= acc_nxt;
    if (s4_last_r) begin
      smoothed_r <= sat_nxt;
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
      s3_valid_r <= 1'b0;
      s3_last_r  <= 1'b0;
      s4_last_r  <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      s1_valid_r <= tap_ctl.valid;
      s1_last_r  <= tap_ctl.valid & tap_ctl.last;
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_last_r;
      s3_valid_r <= s2_valid_r;
      s3_last_r  <= s2_last_r;
      s4_last_r  <= s3_valid_r & s3_last_r;
      done_r     <= s4_last_r;
    end
  end

  assign done     = done_r;
  assign smoothed = smoothed_r;
  assign pending  = s1_valid_r | s2_valid_r | s3_valid_r | s4_last_r;

endmodule

// File: hw/rtl/periodic_gaussian_smooth_3d.sv
`timescale 1ns / 1ps
// Write: busy stays low, writes may follow every cycle; no result.
// In-range query: 27 reads from the single volume memory read port, one neighbor per
// cycle, then the multiply, accumulate, round and saturate stages; busy drops with the
// result strobe, so a new item can be taken in that cycle. Out-of-range query: result
// strobe in the cycle after the accept edge. Results show for one cycle; no stall.
// Reset (rst_n low, synchronous) clears control and restores config; volume is not cleared.
`include "periodic_gaussian_smooth_3d_defines.svh"
module periodic_gaussian_smooth_3d #(
  parameter int MAX_DIM     = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  pgs3d_pkg::in_item_t                   in_item,
  output logic                                  out_valid,
  output pgs3d_pkg::out_item_t                  out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pgs3d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgs3d_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIZE_W = pgs3d_pkg::SIZE_W;
  localparam int WGT_W  = pgs3d_pkg::WGT_W;
  localparam int SMP_W  = pgs3d_pkg::SMP_W;

  localparam logic [SIZE_W-1:0] SIZE_RST          = 6'd32;
  localparam logic [WGT_W-1:0]  WEIGHT_CENTER_RST = 16'd29612;
  localparam logic [WGT_W-1:0]  WEIGHT_SIDE_RST   = 16'd17962;

  logic [SIZE_W-1:0]      size_x_r, size_y_r, size_z_r;
  logic [WGT_W-1:0]       weight_center_r, weight_side_r;
  logic [SIZE_W-1:0]      nx, ny, nz;
  logic                   accept, in_range, launch, ram_we;
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [SAMPLE_BITS-1:0] wdata, rdata;
  logic                   err_valid_r;
  logic                   seq_active, mac_pending, mac_done;
  logic [SMP_W-1:0]       mac_smoothed;
  pgs3d_pkg::tap_ctl_t    tap_ctl;

  // Size in use: zero acts as one, clamp at MAX_DIM
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (int'(s) > MAX_DIM) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Configuration transfer, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r        <= SIZE_RST;
      size_y_r        <= SIZE_RST;
      size_z_r        <= SIZE_RST;
      weight_center_r <= WEIGHT_CENTER_RST;
      weight_side_r   <= WEIGHT_SIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pgs3d_pkg::CFG_SIZE_X:        size_x_r        <= cfg_data[SIZE_W-1:0];
        pgs3d_pkg::CFG_SIZE_Y:        size_y_r        <= cfg_data[SIZE_W-1:0];
        pgs3d_pkg::CFG_SIZE_Z:        size_z_r        <= cfg_data[SIZE_W-1:0];
        pgs3d_pkg::CFG_WEIGHT_CENTER: weight_center_r <= cfg_data[WGT_W-1:0];
        pgs3d_pkg::CFG_WEIGHT_SIDE:   weight_side_r   <= cfg_data[WGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign nx = eff_size(size_x_r);
  assign ny = eff_size(size_y_r);
  assign nz = eff_size(size_z_r);

  // Item decode
  assign accept   = start && !busy;
  assign in_range = (SIZE_W'(in_item.coord_x) < nx) && (SIZE_W'(in_item.coord_y) < ny) &&
                    (SIZE_W'(in_item.coord_z) < nz);
  assign ram_we   = accept && (in_item.operation == pgs3d_pkg::OP_WRITE) && in_range;
  assign launch   = accept && (in_item.operation == pgs3d_pkg::OP_QUERY) && in_range;

  // Writes land at the accept edge, so a following query always reads fresh data
  assign waddr = ADDR_W'(in_item.coord_x) + ADDR_W'(MAX_DIM) *
                 (ADDR_W'(in_item.coord_y) + ADDR_W'(MAX_DIM) * ADDR_W'(in_item.coord_z));
  assign wdata = SAMPLE_BITS'(in_item.sample);

  pgs3d_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_volume (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pgs3d_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .launch  (launch),
    .coord_x (in_item.coord_x),
    .coord_y (in_item.coord_y),
    .coord_z (in_item.coord_z),
    .size_x  (nx),
    .size_y  (ny),
    .size_z  (nz),
    .raddr   (raddr),
    .tap_ctl (tap_ctl),
    .active  (seq_active)
  );

  pgs3d_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .launch        (launch),
    .tap_ctl       (tap_ctl),
    .rd_data       (rdata),
    .weight_center (weight_center_r),
    .weight_side   (weight_side_r),
    .done          (mac_done),
    .smoothed      (mac_smoothed),
    .pending       (mac_pending)
  );

  // Out-of-range query answers right away
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_valid_r <= 1'b0;
    end else begin
      err_valid_r <= accept && (in_item.operation == pgs3d_pkg::OP_QUERY) && !in_range;
    end
  end

  assign busy                 = seq_active | mac_pending;
  assign out_valid            = mac_done | err_valid_r;
  assign out_item.smoothed    = err_valid_r ? '0 : mac_smoothed;
  assign out_item.range_error = err_valid_r;

  // Checks
  `PGS3D_ASSERT_NEVER(a_one_result_source, clk, rst_n, err_valid_r && mac_done, "results collide")
  `PGS3D_ASSERT(a_launch_busy, clk, rst_n, launch |=> busy, "query started but block not busy")
  `PGS3D_ASSERT(a_done_after_busy, clk, rst_n, mac_done |-> $past(busy), "result without query")
  `PGS3D_ASSERT(a_tap_in_query, clk, rst_n, tap_ctl.valid |-> busy, "tap issued while idle")

endmodule

// File: sim/pgs3d_tb_pkg.sv
`timescale 1ns / 1ps
package pgs3d_tb_pkg;
  import pgs3d_pkg::*;

  localparam int GRID      = 32;
  localparam int PRINT_CAP = 40;

  // Mirror of the volume and the registers; predicts one result per query
  class smooth_scoreboard;
    bit [SMP_W-1:0]  volume [GRID*GRID*GRID];
    bit              loaded [GRID*GRID*GRID];
    bit [SIZE_W-1:0] size_reg [3];
    bit [WGT_W-1:0]  w_center;
    bit [WGT_W-1:0]  w_side;
    out_item_t       expected_q [$];
    int unsigned     mismatches;
    int unsigned     results_seen;
    int unsigned     smooth_queries;
    int unsigned     range_errors;
    int unsigned     saturated;
    int unsigned     writes_kept;
    int unsigned     writes_dropped;

    function new();
      size_reg[0] = 6'd32;
      size_reg[1] = 6'd32;
      size_reg[2] = 6'd32;
      w_center    = 16'd29612;
      w_side      = 16'd17962;
    endfunction

    // Size in use: zero acts as one, anything past the grid as the grid
    function int unsigned axis_len(int a);
      if (size_reg[a] == 0) return 1;
      if (size_reg[a] > GRID) return GRID;
      return size_reg[a];
    endfunction

    function int unsigned voxel_addr(int unsigned x, int unsigned y, int unsigned z);
      return x + GRID * (y + GRID * z);
    endfunction

    // Neighbor along one axis for offset k-1, periodic
    function int unsigned wrap_axis(int unsigned c, int unsigned k, int unsigned n);
      if (k == 0) return (c == 0) ? n - 1 : c - 1;
      if (k == 1) return c;
      return (c + 1 >= n) ? 0 : c + 1;
    endfunction

    function longint unsigned tap_weight(int unsigned k);
      return (k == 1) ? longint'(w_center) : longint'(w_side);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // True when all 27 neighbors of the coordinate hold written data
    function bit nbhd_loaded(int unsigned x, int unsigned y, int unsigned z);
      int unsigned nx, ny, nz;
      nx = axis_len(0);
      ny = axis_len(1);
      nz = axis_len(2);
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++)
          for (int i = 0; i < 3; i++)
            if (!loaded[voxel_addr(wrap_axis(x, i, nx), wrap_axis(y, j, ny),
                                   wrap_axis(z, k, nz))])
              return 0;
      return 1;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SIZE_X:        size_reg[0] = data[SIZE_W-1:0];
        CFG_SIZE_Y:        size_reg[1] = data[SIZE_W-1:0];
        CFG_SIZE_Z:        size_reg[2] = data[SIZE_W-1:0];
        CFG_WEIGHT_CENTER: w_center = data;
        CFG_WEIGHT_SIDE:   w_side = data;
        default: ;
      endcase
    endfunction

    // Accepted input: update the volume, or queue the expected query result
    function void note_input(in_item_t it);
      int unsigned       c[3];
      int unsigned       n[3];
      bit                in_rng;
      longint unsigned   acc;
      longint unsigned   w;
      int unsigned       a;
      out_item_t         r;
      c[0] = it.coord_x;
      c[1] = it.coord_y;
      c[2] = it.coord_z;
      for (int i = 0; i < 3; i++) n[i] = axis_len(i);
      in_rng = c[0] < n[0] && c[1] < n[1] && c[2] < n[2];
      if (it.operation == OP_WRITE) begin
        if (in_rng) begin
          volume[voxel_addr(c[0], c[1], c[2])] = it.sample;
          loaded[voxel_addr(c[0], c[1], c[2])] = 1'b1;
          writes_kept++;
        end else begin
          writes_dropped++;
        end
        return;
      end
      r = '0;
      if (!in_rng) begin
        r.range_error = 1'b1;
        range_errors++;
      end else begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++) begin
              w = (((tap_weight(i) * tap_weight(j)) >> 16) * tap_weight(k)) >> 16;
              a = voxel_addr(wrap_axis(c[0], i, n[0]), wrap_axis(c[1], j, n[1]),
                             wrap_axis(c[2], k, n[2]));
              acc += volume[a] * w;
            end
        acc = (acc + 32768) >> 16;
        if (acc > 65535) begin
          acc = 65535;
          saturated++;
        end
        r.smoothed = acc[SMP_W-1:0];
        smooth_queries++;
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH: %s", msg);
    endtask

    // Result transfer: compare with the oldest expectation
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: smoothed %0d range_error %0b",
                         got.smoothed, got.range_error));
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (got.smoothed !== want.smoothed)
        report($sformatf("result %0d: smoothed %0d, expected %0d",
                         results_seen, got.smoothed, want.smoothed));
      if (got.range_error !== want.range_error)
        report($sformatf("result %0d: range_error %0b, expected %0b",
                         results_seen, got.range_error, want.range_error));
    endtask
  endclass

endpackage

// File: sim/tb_periodic_gaussian_smooth_3d.sv
`timescale 1ns / 1ps
module tb_periodic_gaussian_smooth_3d;
  import pgs3d_pkg::*;
  import pgs3d_tb_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 110;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  smooth_scoreboard sb;
  bit               steady;
  int unsigned      box_org[3];
  int unsigned      box_len[3];
  int unsigned      idle_cycles;
  int unsigned      items_sent;
  int unsigned      settings_used;

  periodic_gaussian_smooth_3d dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Watchdog: any transfer restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("** periodic_gaussian_smooth_3d: FAILED **");
        $finish;
      end
    end
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 9);
  endfunction

  function automatic in_item_t make_item(logic op, int unsigned x, int unsigned y,
                                         int unsigned z, logic [SMP_W-1:0] smp);
    in_item_t it;
    it.operation = op;
    it.coord_x   = x[COORD_W-1:0];
    it.coord_y   = y[COORD_W-1:0];
    it.coord_z   = z[COORD_W-1:0];
    it.sample    = smp;
    return it;
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Size register word; junk above the size bits now and then
  function automatic logic [CFG_DATA_W-1:0] size_word(int unsigned s);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 3) != 0) v = '0;
    v[SIZE_W-1:0] = s[SIZE_W-1:0];
    return v;
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32;
      2: return $urandom_range(33, 63);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return WGT_W'($urandom);
    endcase
  endfunction

  // Input transfer; outside steady phases start may drop at random, also while waiting on busy
  task automatic send_item(input in_item_t it);
    bit done;
    bit drive;
    done = 0;
    while (!done) begin
      @(negedge clk);
      drive = !take_gap();
      start   <= drive;
      in_item <= it;
      @(posedge clk);
      if (drive && !busy) done = 1;
    end
    sb.note_input(it);
    items_sent++;
  endtask

  // Register transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    bit done;
    bit drive;
    done = 0;
    while (!done) begin
      @(negedge clk);
      drive = !take_gap();
      cfg_valid <= drive;
      cfg_index <= idx;
      cfg_data  <= data;
      @(posedge clk);
      if (drive && cfg_ready) done = 1;
    end
    sb.configure(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop start and wait until every expected result is in
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write every voxel of the box so that its inner points can be queried
  task automatic load_box();
    int unsigned n[3];
    for (int a = 0; a < 3; a++) n[a] = sb.axis_len(a);
    for (int k = 0; k < box_len[2]; k++)
      for (int j = 0; j < box_len[1]; j++)
        for (int i = 0; i < box_len[0]; i++)
          send_item(make_item(OP_WRITE, (box_org[0] + i) % n[0], (box_org[1] + j) % n[1],
                              (box_org[2] + k) % n[2], pick_sample()));
  endtask

  // In-range query inside the box; falls back to a fixed inner point if a neighbor is unwritten
  task automatic query_near_box();
    int unsigned c[3];
    int unsigned n[3];
    for (int a = 0; a < 3; a++) begin
      n[a] = sb.axis_len(a);
      c[a] = (box_org[a] + $urandom_range(0, box_len[a] - 1)) % n[a];
    end
    if (!sb.nbhd_loaded(c[0], c[1], c[2]))
      for (int a = 0; a < 3; a++) c[a] = (box_org[a] + (box_len[a] >= 3)) % n[a];
    send_item(make_item(OP_QUERY, c[0], c[1], c[2], pick_sample()));
  endtask

  // New register setting, written in random order, then a fresh box
  task automatic start_phase(input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
                             input logic [CFG_DATA_W-1:0] sz, input logic [WGT_W-1:0] wc,
                             input logic [WGT_W-1:0] ws);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    logic [CFG_IDX_W-1:0]  ti;
    logic [CFG_DATA_W-1:0] tv;
    int unsigned           j;
    settle();
    idx[0] = CFG_SIZE_X;        val[0] = sx;
    idx[1] = CFG_SIZE_Y;        val[1] = sy;
    idx[2] = CFG_SIZE_Z;        val[2] = sz;
    idx[3] = CFG_WEIGHT_CENTER; val[3] = wc;
    idx[4] = CFG_WEIGHT_SIDE;   val[4] = ws;
    for (int i = 4; i > 0; i--) begin
      j = $urandom_range(0, i);
      ti = idx[i]; idx[i] = idx[j]; idx[j] = ti;
      tv = val[i]; val[i] = val[j]; val[j] = tv;
    end
    for (int i = 0; i < 5; i++) begin
      write_reg(idx[i], val[i]);
      // index past the register list: must be ignored
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_WEIGHT_SIDE + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
    end
    settings_used++;
    for (int a = 0; a < 3; a++) begin
      box_len[a] = (sb.axis_len(a) < 4) ? sb.axis_len(a) : 4;
      box_org[a] = $urandom_range(0, sb.axis_len(a) - 1);
    end
    load_box();
  endtask

  // Mixed writes and queries; drains once halfway through
  task automatic run_traffic(input int unsigned count);
    int unsigned c[3];
    int unsigned n[3];
    int unsigned r;
    for (int a = 0; a < 3; a++) n[a] = sb.axis_len(a);
    for (int unsigned t = 0; t < count; t++) begin
      if (t == count / 2) settle();
      r = $urandom_range(0, 99);
      if (r < 35) begin
        for (int a = 0; a < 3; a++) c[a] = $urandom_range(0, n[a] - 1);
        send_item(make_item(OP_WRITE, c[0], c[1], c[2], pick_sample()));
      end else if (r < 45) begin
        for (int a = 0; a < 3; a++) c[a] = $urandom_range(0, 31);
        send_item(make_item(OP_WRITE, c[0], c[1], c[2], pick_sample()));
      end else if (r < 85) begin
        query_near_box();
      end else begin
        for (int a = 0; a < 3; a++) c[a] = $urandom_range(0, 31);
        if (c[0] < n[0] && c[1] < n[1] && c[2] < n[2] && !sb.nbhd_loaded(c[0], c[1], c[2]))
          query_near_box();
        else
          send_item(make_item(OP_QUERY, c[0], c[1], c[2], pick_sample()));
      end
    end
  endtask

  initial begin
    sb = new();
    steady = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: corner box across the wrap on every axis of the full grid
    for (int a = 0; a < 3; a++) begin
      box_org[a] = 30;
      box_len[a] = 3;
    end
    load_box();
    send_item(make_item(OP_QUERY, 31, 31, 31, '0));
    send_item(make_item(OP_QUERY, 31, 31, 31, '1));

    // Extreme settings: sizes zero and past the grid, full and zero taps
    start_phase(size_word(0), size_word(63), size_word(2), '1, '1);
    run_traffic(ITEMS_PER_PHASE);
    start_phase(size_word(4), size_word(4), size_word(4), '0, '0);
    run_traffic(ITEMS_PER_PHASE);
    start_phase(size_word(32), size_word(3), size_word(1), '0, '1);
    run_traffic(ITEMS_PER_PHASE);
    start_phase(size_word(1), size_word(1), size_word(1), '1, '0);
    run_traffic(ITEMS_PER_PHASE);

    // Random settings; one of them runs with no gaps at all
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      start_phase(size_word(pick_size()), size_word(pick_size()), size_word(pick_size()),
                  pick_weight(), pick_weight());
      steady = (p == 2);
      run_traffic(ITEMS_PER_PHASE);
      steady = 0;
    end

    settle();
    repeat (40) @(posedge clk);

    $display("covered %0d items over %0d register settings: %0d smoothed queries, %0d saturated",
             items_sent, settings_used + 1, sb.smooth_queries, sb.saturated);
    $display("%0d out-of-range queries, %0d writes stored, %0d writes ignored, %0d mismatches",
             sb.range_errors, sb.writes_kept, sb.writes_dropped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** periodic_gaussian_smooth_3d: PASSED **");
    end else begin
      $display("** periodic_gaussian_smooth_3d: FAILED **");
    end
    $finish;
  end

endmodule
